// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
// No dependencies; take in with `include before use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with a custom message, reset disables it.
`define PBPG_ASSERT_MSG(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same with a generic message.
`define PBPG_ASSERT(lbl, clk, rst_n, prop) \
    `PBPG_ASSERT_MSG(lbl, clk, rst_n, prop, "pbpg assertion failed")

`endif

// ----- hw/rtl/pbpg_pkg.sv -----
// Package for the proximity beep pattern generator: widths, register
// indexes, sequencer states and divider interface structs. No dependencies.
package pbpg_pkg;

    localparam int TICKS_PER_MS = 4;
    localparam int TICK_DIV_W   = (TICKS_PER_MS > 1) ? $clog2(TICKS_PER_MS) : 1;

    localparam int DIST_W  = 13;
    localparam int PER_W   = 16;
    localparam int OOR_W   = 15;
    localparam int MS_W    = 32;
    localparam int PROD_W  = DIST_W + PER_W;
    localparam int STEP_W  = $clog2(PROD_W);
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 40;

    localparam logic [CFG_IDX_W-1:0] REG_WARN_DIST = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_DIST = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FAST_PER  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_PER  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BEEP_ON   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OOR_CODE  = 3'd5;

    localparam logic [1:0] MODE_OFF    = 2'd0;
    localparam logic [1:0] MODE_PULSED = 2'd1;
    localparam logic [1:0] MODE_CONT   = 2'd2;

    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_DIST = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_START,
        ST_WAIT
    } t_state;

    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] dividend;
        logic [DIST_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] quotient;
    } t_div_rsp;

endpackage

// ----- hw/rtl/proximity_beep_pattern_generator_top.sv -----
// Top level of the proximity beep pattern generator: tick handling, distance
// classification, beep sequencer. Depends on pbpg_pkg and pbpg_div.
//
//  channel   | direction | payload
//  ----------+-----------+----------------------------------------------
//  s_axis    | in        | tuser = func, tdata = distance_mm
//  m_axis    | out       | tdata = level, tone, mode, millisecond count
//  cfg       | in        | we / idx / data, six registers, write only
//
// Flow: a tone tick and most distance transfers finish in the accept cycle,
// the result is valid on the next cycle. A pulsed reading that ends the
// sounding phase goes through the multiply (ST_MUL), the divider start (ST_START),
// 29 divider steps in pbpg_div (one quotient bit each) and the response.
// Reset is synchronous, active low; it loads the register defaults and
// clears all beep state. Input ready is low while an item is in work and
// while a result waits on a stalled output.
module proximity_beep_pattern_generator_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // slave stream
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [pbpg_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,  // [15:0] distance_mm
    input  logic                                i_s_axis_tuser,  // [0] func
    // master stream
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [0] buzzer_level, [1] tone_active, [3:2] warn_mode,
    // [35:4] millisecond_count, [39:36] zero
    output logic [pbpg_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata,
    // config write port
    input  logic                                i_cfg_we,
    input  logic [pbpg_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [pbpg_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    // configuration registers
    logic [pbpg_pkg::DIST_W-1:0] r_warn, r_stop;
    logic [pbpg_pkg::PER_W-1:0]  r_fast, r_slow, r_beep_on;
    logic [pbpg_pkg::OOR_W-1:0]  r_oor;

    // beep state
    logic                              r_pin, n_pin;
    logic                              r_tone, n_tone;
    logic [pbpg_pkg::TICK_DIV_W-1:0]   r_tick_div, n_tick_div;
    logic [pbpg_pkg::MS_W-1:0]         r_ms, n_ms;
    logic [1:0]                        r_mode, n_mode;
    logic                              r_phase, n_phase;
    logic [pbpg_pkg::MS_W-1:0]         r_next_t, n_next_t;
    logic                              r_out_valid, n_out_valid;

    pbpg_pkg::t_state r_state, n_state;

    // operands of the interpolation
    logic [pbpg_pkg::DIST_W-1:0] r_span, r_den;
    logic [pbpg_pkg::PER_W-1:0]  r_diff;
    logic [pbpg_pkg::PROD_W-1:0] r_prod;

    pbpg_pkg::t_div_req div_req;
    pbpg_pkg::t_div_rsp div_rsp;

    logic                        accept, finish, need_div, div_start;
    logic signed [15:0]          dist_mm;
    logic                        is_off, is_cont;
    logic [pbpg_pkg::DIST_W-1:0] span_w, den_w;
    logic [pbpg_pkg::PER_W-1:0]  diff_w;
    logic [pbpg_pkg::PER_W:0]    period, off_ms;

    assign accept  = i_s_axis_tvalid && o_s_axis_tready;
    assign dist_mm = i_s_axis_tdata;

    // classification of the reading
    assign is_off  = dist_mm[15] || (dist_mm == 16'sd0)
                     || (dist_mm[pbpg_pkg::OOR_W-1:0] == r_oor)
                     || (16'(dist_mm) > {3'b000, r_warn});
    assign is_cont = (16'(dist_mm) <= {3'b000, r_stop});
    assign span_w  = dist_mm[pbpg_pkg::DIST_W-1:0] - r_stop;
    assign den_w   = r_warn - r_stop;
    assign diff_w  = (r_slow > r_fast) ? (r_slow - r_fast) : '0;

    // due when the wrapped difference now - next is not negative
    logic [pbpg_pkg::MS_W-1:0] due_diff;
    logic                      due;
    assign due_diff = r_ms - r_next_t;
    assign due      = !due_diff[pbpg_pkg::MS_W-1];

    // only the end of a sounding phase needs the interpolated period
    assign need_div = (i_s_axis_tuser == pbpg_pkg::FUNC_DIST) && !is_off && !is_cont
                      && (r_mode == pbpg_pkg::MODE_PULSED) && due && r_phase;

    assign finish = (accept && !need_div)
                    || ((r_state == pbpg_pkg::ST_WAIT) && div_rsp.done);

    assign period = {1'b0, r_fast} + {1'b0, div_rsp.quotient[pbpg_pkg::PER_W-1:0]};
    assign off_ms = (period > {1'b0, r_beep_on}) ? (period - {1'b0, r_beep_on}) : '0;

    // state update
    always_comb begin
        n_pin      = r_pin;
        n_tone     = r_tone;
        n_tick_div = r_tick_div;
        n_ms       = r_ms;
        n_mode     = r_mode;
        n_phase    = r_phase;
        n_next_t   = r_next_t;
        if (accept && (i_s_axis_tuser == pbpg_pkg::FUNC_TICK)) begin
            n_pin = r_tone ? !r_pin : 1'b0;
            if (r_tick_div == pbpg_pkg::TICK_DIV_W'(pbpg_pkg::TICKS_PER_MS - 1)) begin
                n_tick_div = '0;
                n_ms       = r_ms + 1'b1;
            end else begin
                n_tick_div = r_tick_div + 1'b1;
            end
        end else if (accept) begin
            priority if (is_off) begin
                n_tone   = 1'b0;
                n_pin    = 1'b0;
                n_mode   = pbpg_pkg::MODE_OFF;
                n_phase  = 1'b0;
                n_next_t = r_ms;
            end else if (is_cont) begin
                n_tone = 1'b1;
                n_mode = pbpg_pkg::MODE_CONT;
            end else if (r_mode != pbpg_pkg::MODE_PULSED) begin
                // entering pulsed mode: start sounding
                n_mode   = pbpg_pkg::MODE_PULSED;
                n_phase  = 1'b1;
                n_tone   = 1'b1;
                n_next_t = r_ms + {16'd0, r_beep_on};
            end else if (due && !r_phase) begin
                n_phase  = 1'b1;
                n_tone   = 1'b1;
                n_next_t = r_ms + {16'd0, r_beep_on};
            end else begin
                // not due, or end of sounding handled after the divide
            end
        end else if ((r_state == pbpg_pkg::ST_WAIT) && div_rsp.done) begin
            n_phase  = 1'b0;
            n_tone   = 1'b0;
            n_next_t = r_ms + {15'd0, off_ms};
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (finish) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pbpg_pkg::ST_IDLE: begin
                if (accept && need_div) begin
                    n_state = pbpg_pkg::ST_MUL;
                end
            end
            pbpg_pkg::ST_MUL:   n_state = pbpg_pkg::ST_START;
            pbpg_pkg::ST_START: n_state = pbpg_pkg::ST_WAIT;
            pbpg_pkg::ST_WAIT: begin
                if (div_rsp.done) begin
                    n_state = pbpg_pkg::ST_IDLE;
                end
            end
            default: n_state = pbpg_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_s_axis_tready = 1'b0;
        div_start       = 1'b0;
        unique case (r_state)
            pbpg_pkg::ST_IDLE:  o_s_axis_tready = !r_out_valid || i_m_axis_tready;
            pbpg_pkg::ST_MUL:   div_start = 1'b0;
            pbpg_pkg::ST_START: div_start = 1'b1;
            pbpg_pkg::ST_WAIT:  div_start = 1'b0;
            default:            div_start = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_warn      <= pbpg_pkg::DIST_W'(200);
            r_stop      <= pbpg_pkg::DIST_W'(100);
            r_fast      <= pbpg_pkg::PER_W'(150);
            r_slow      <= pbpg_pkg::PER_W'(600);
            r_beep_on   <= pbpg_pkg::PER_W'(50);
            r_oor       <= pbpg_pkg::OOR_W'(8190);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pbpg_pkg::REG_WARN_DIST: r_warn    <= i_cfg_data[pbpg_pkg::DIST_W-1:0];
                pbpg_pkg::REG_STOP_DIST: r_stop    <= i_cfg_data[pbpg_pkg::DIST_W-1:0];
                pbpg_pkg::REG_FAST_PER:  r_fast    <= i_cfg_data;
                pbpg_pkg::REG_SLOW_PER:  r_slow    <= i_cfg_data;
                pbpg_pkg::REG_BEEP_ON:   r_beep_on <= i_cfg_data;
                pbpg_pkg::REG_OOR_CODE:  r_oor     <= i_cfg_data[pbpg_pkg::OOR_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pin       <= 1'b0;
            r_tone      <= 1'b0;
            r_tick_div  <= '0;
            r_ms        <= '0;
            r_mode      <= pbpg_pkg::MODE_OFF;
            r_phase     <= 1'b0;
            r_next_t    <= '0;
            r_out_valid <= 1'b0;
            r_state     <= pbpg_pkg::ST_IDLE;
        end else begin
            r_pin       <= n_pin;
            r_tone      <= n_tone;
            r_tick_div  <= n_tick_div;
            r_ms        <= n_ms;
            r_mode      <= n_mode;
            r_phase     <= n_phase;
            r_next_t    <= n_next_t;
            r_out_valid <= n_out_valid;
            r_state     <= n_state;
        end
    end

    // interpolation operands, then one registered multiply
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_span <= span_w;
            r_den  <= den_w;
            r_diff <= diff_w;
        end
        if (r_state == pbpg_pkg::ST_MUL) begin
            r_prod <= r_span * r_diff;
        end
    end

    assign div_req.start    = div_start;
    assign div_req.dividend = r_prod;
    assign div_req.divisor  = r_den;

    pbpg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // state only moves on accepted items, so the result reads straight from it
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'b0000, r_ms, r_mode, r_tone, r_pin};

endmodule

// ----- hw/rtl/pbpg_div.sv -----
// Restoring divider, one quotient bit per cycle.
// Depends on pbpg_pkg (widths, request/response structs).
module pbpg_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pbpg_pkg::t_div_req  i_req,
    output pbpg_pkg::t_div_rsp  o_rsp
);

    logic                          r_busy, n_busy;
    logic                          r_done, n_done;
    logic [pbpg_pkg::STEP_W-1:0]   r_step, n_step;
    logic [pbpg_pkg::DIST_W:0]     r_rem, n_rem;
    logic [pbpg_pkg::PROD_W-1:0]   r_quo, n_quo;
    logic [pbpg_pkg::DIST_W-1:0]   r_den, n_den;
    logic [pbpg_pkg::DIST_W:0]     rem_sh;
    logic                          q_bit;

    // shift in next dividend bit, trial subtract
    assign rem_sh = {r_rem[pbpg_pkg::DIST_W-1:0], r_quo[pbpg_pkg::PROD_W-1]};
    assign q_bit  = (rem_sh >= {1'b0, r_den});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_step = r_step;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_den  = r_den;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_step = '0;
            n_rem  = '0;
            n_quo  = i_req.dividend;
            n_den  = i_req.divisor;
        end else if (r_busy) begin
            n_rem  = q_bit ? (rem_sh - {1'b0, r_den}) : rem_sh;
            n_quo  = {r_quo[pbpg_pkg::PROD_W-2:0], q_bit};
            n_step = r_step + 1'b1;
            if (r_step == pbpg_pkg::STEP_W'(pbpg_pkg::PROD_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_step <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

// ----- hw/rtl/pbpg_checker.sv -----
// Port-level checker for the proximity beep pattern generator, bound to
// the top level. Depends on assert_macros.svh and pbpg_pkg.
`include "assert_macros.svh"

module pbpg_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_m_axis_tvalid,
    input logic                              i_m_axis_tready,
    input logic [pbpg_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata
);

    // a stalled result stays offered
    `PBPG_ASSERT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)

    // no mode code beyond continuous
    `PBPG_ASSERT(a_mode_legal, i_clk, i_rst_n, o_m_axis_tvalid |-> (o_m_axis_tdata[3:2] != 2'b11))

    // silent mode means tone off and pin low
    `PBPG_ASSERT_MSG(a_off_silent, i_clk, i_rst_n, o_m_axis_tvalid && (o_m_axis_tdata[3:2] == pbpg_pkg::MODE_OFF) |-> (o_m_axis_tdata[1:0] == 2'b00), "off mode not silent")

    // continuous mode keeps the tone enabled
    `PBPG_ASSERT_MSG(a_cont_tone, i_clk, i_rst_n, o_m_axis_tvalid && (o_m_axis_tdata[3:2] == pbpg_pkg::MODE_CONT) |-> o_m_axis_tdata[1], "continuous mode without tone")

endmodule

bind proximity_beep_pattern_generator_top pbpg_checker u_pbpg_checker (.*);

// ----- tb/proximity_beep_pattern_generator_top_tb.sv -----
// Self-checking testbench for proximity_beep_pattern_generator_top.
// Depends on pbpg_pkg and the block's RTL. A local predictor of the buzzer state
// supplies the expected value of every output transfer.
module proximity_beep_pattern_generator_top_tb;

    // Generous upper bound on the run. The slowest correct run is about
    // 1300 items, some with a divide, plus a heavily stalled receiver.
    localparam int CYCLE_LIMIT   = 600000;
    localparam int MAX_REPORTS   = 10;
    localparam int RANDOM_ITEMS  = 420;   // per flow-control mix, split over the profiles
    localparam int NUM_PROFILES  = 4;
    localparam int DRAIN_CYCLES  = 40;

    // One output transfer, field by field.
    typedef struct packed {
        logic        level;
        logic        tone;
        logic [1:0]  mode;
        logic [31:0] ms;
    } t_beep_result;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_s_axis_tvalid = 1'b0;
    logic                            o_s_axis_tready;
    logic [pbpg_pkg::IN_DATA_W-1:0]  i_s_axis_tdata = '0;   // [15:0] distance_mm
    logic                            i_s_axis_tuser = pbpg_pkg::FUNC_TICK;  // [0] func
    logic                            o_m_axis_tvalid;
    logic                            i_m_axis_tready = 1'b0;
    // [0] level, [1] tone, [3:2] mode, [35:4] millisecond count
    logic [pbpg_pkg::OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                            i_cfg_we = 1'b0;
    logic [pbpg_pkg::CFG_IDX_W-1:0]  i_cfg_idx = pbpg_pkg::REG_WARN_DIST;
    logic [pbpg_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    proximity_beep_pattern_generator_top DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: register copies and buzzer state, reset values.
    // ------------------------------------------------------------------
    logic [pbpg_pkg::DIST_W-1:0]     cfg_warn    = 13'd200;
    logic [pbpg_pkg::DIST_W-1:0]     cfg_stop    = 13'd100;
    logic [pbpg_pkg::PER_W-1:0]      cfg_fast    = 16'd150;
    logic [pbpg_pkg::PER_W-1:0]      cfg_slow    = 16'd600;
    logic [pbpg_pkg::PER_W-1:0]      cfg_beep_on = 16'd50;
    logic [pbpg_pkg::OOR_W-1:0]      cfg_oor     = 15'd8190;

    logic                            pin_q   = 1'b0;
    logic                            tone_q  = 1'b0;
    logic [pbpg_pkg::TICK_DIV_W-1:0] div_q   = '0;
    logic [pbpg_pkg::MS_W-1:0]       ms_q    = '0;
    logic [1:0]                      mode_q  = pbpg_pkg::MODE_OFF;
    logic                            phase_q = 1'b0;   // 1 = sounding part of a beep
    logic [pbpg_pkg::MS_W-1:0]       next_q  = '0;     // ms time of the next beep edge

    t_beep_result expected_beeps[$];

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int error_count = 0;
    int cycle_count = 0;
    int items_sent = 0;
    int results_checked = 0;
    int distance_updates = 0;
    int pulsed_results = 0;

    // Advance the buzzer state by one input item and return the result.
    function automatic t_beep_result predict_beep(input logic func, input logic [15:0] raw);
        t_beep_result              res;
        int                        dv;
        int                        diff;
        int                        period;
        int                        off_ms;
        logic [pbpg_pkg::MS_W-1:0] delta;
        dv = int'($signed(raw));
        if (func == pbpg_pkg::FUNC_TICK) begin
            // tick: toggle while the tone is on, hold low otherwise
            pin_q = tone_q ? ~pin_q : 1'b0;
            if (int'(div_q) + 1 >= pbpg_pkg::TICKS_PER_MS) begin
                div_q = '0;
                ms_q  = ms_q + 1;
            end else begin
                div_q = div_q + 1'b1;
            end
        end else if (dv <= 0 || dv == int'(cfg_oor) || dv > int'(cfg_warn)) begin
            // invalid, out-of-range or far: silence, sequencer rearmed at now
            tone_q  = 1'b0;
            pin_q   = 1'b0;
            mode_q  = pbpg_pkg::MODE_OFF;
            phase_q = 1'b0;
            next_q  = ms_q;
        end else if (dv <= int'(cfg_stop)) begin
            // close: continuous tone, sequencer timing left alone
            tone_q = 1'b1;
            mode_q = pbpg_pkg::MODE_CONT;
        end else begin
            diff   = (cfg_slow > cfg_fast) ? int'(cfg_slow) - int'(cfg_fast) : 0;
            period = int'(cfg_fast) + ((dv - int'(cfg_stop)) * diff) /
                     (int'(cfg_warn) - int'(cfg_stop));
            if (mode_q != pbpg_pkg::MODE_PULSED) begin
                // entering pulsed mode starts with the sounding phase
                mode_q  = pbpg_pkg::MODE_PULSED;
                phase_q = 1'b1;
                tone_q  = 1'b1;
                next_q  = ms_q + pbpg_pkg::MS_W'(cfg_beep_on);
            end else begin
                delta = ms_q - next_q;
                if (!delta[pbpg_pkg::MS_W-1]) begin
                    if (phase_q) begin
                        off_ms  = (period > int'(cfg_beep_on)) ?
                                  period - int'(cfg_beep_on) : 0;
                        phase_q = 1'b0;
                        tone_q  = 1'b0;
                        next_q  = ms_q + pbpg_pkg::MS_W'(off_ms);
                    end else begin
                        phase_q = 1'b1;
                        tone_q  = 1'b1;
                        next_q  = ms_q + pbpg_pkg::MS_W'(cfg_beep_on);
                    end
                end
            end
        end
        res.level = pin_q;
        res.tone  = tone_q;
        res.mode  = mode_q;
        res.ms    = ms_q;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Monitor: compare each output transfer with the oldest expectation,
    // then predict for the input transfer of the same edge. An output can
    // never belong to an input taken at the same edge, so order is safe.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_beep_result exp_r;
        t_beep_result got_r;
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got_r.level = o_m_axis_tdata[0];
                got_r.tone  = o_m_axis_tdata[1];
                got_r.mode  = o_m_axis_tdata[3:2];
                got_r.ms    = o_m_axis_tdata[35:4];
                if (expected_beeps.size() == 0) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("ERROR: unexpected output transfer %h", o_m_axis_tdata);
                end else begin
                    exp_r = expected_beeps.pop_front();
                    results_checked++;
                    if (got_r.mode == pbpg_pkg::MODE_PULSED)
                        pulsed_results++;
                    if (got_r.level !== exp_r.level || got_r.tone !== exp_r.tone ||
                        got_r.mode !== exp_r.mode || got_r.ms !== exp_r.ms) begin
                        error_count++;
                        if (error_count <= MAX_REPORTS)
                            $display({"ERROR: result %0d level %b/%b tone %b/%b ",
                                      "mode %0d/%0d ms %0d/%0d (exp/got)"},
                                     results_checked, exp_r.level, got_r.level,
                                     exp_r.tone, got_r.tone, exp_r.mode, got_r.mode,
                                     exp_r.ms, got_r.ms);
                    end
                end
            end
            if (i_s_axis_tvalid && o_s_axis_tready)
                expected_beeps.push_back(predict_beep(i_s_axis_tuser, i_s_axis_tdata));
        end
    end

    // Receiver backpressure, changed at the falling edge.
    always @(negedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_beeps.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers. All run at the falling edge.
    // ------------------------------------------------------------------

    // One input transfer. Returns at the falling edge after acceptance with
    // tvalid still high, so back-to-back calls need no extra assignment.
    task automatic send_event(input logic func, input logic [15:0] dist_mm);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= func;
        i_s_axis_tdata  <= dist_mm;
        do
            @(posedge i_clk);
        while (!o_s_axis_tready);
        @(negedge i_clk);
        items_sent++;
        if (func == pbpg_pkg::FUNC_DIST)
            distance_updates++;
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_event(pbpg_pkg::FUNC_TICK, 16'($urandom()));
    endtask

    // Drop tvalid and wait for every expected result.
    task automatic wait_idle();
        i_s_axis_tvalid <= 1'b0;
        while (expected_beeps.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // One register write; the caller lowers the write enable afterwards.
    task automatic write_reg(input logic [pbpg_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        case (idx)
            pbpg_pkg::REG_WARN_DIST: cfg_warn    = data[pbpg_pkg::DIST_W-1:0];
            pbpg_pkg::REG_STOP_DIST: cfg_stop    = data[pbpg_pkg::DIST_W-1:0];
            pbpg_pkg::REG_FAST_PER:  cfg_fast    = data;
            pbpg_pkg::REG_SLOW_PER:  cfg_slow    = data;
            pbpg_pkg::REG_BEEP_ON:   cfg_beep_on = data;
            pbpg_pkg::REG_OOR_CODE:  cfg_oor     = data[pbpg_pkg::OOR_W-1:0];
            default: ;
        endcase
    endtask

    // Write all six registers; unused upper data bits carry random junk.
    task automatic set_config(input int warn, input int stop, input int fast,
                              input int slow, input int beep_on, input int oor);
        logic [15:0] junk;
        wait_idle();
        junk = 16'($urandom());
        write_reg(pbpg_pkg::REG_WARN_DIST, {junk[15:13], 13'(warn)});
        write_reg(pbpg_pkg::REG_STOP_DIST, {junk[12:10], 13'(stop)});
        write_reg(pbpg_pkg::REG_FAST_PER,  16'(fast));
        write_reg(pbpg_pkg::REG_SLOW_PER,  16'(slow));
        write_reg(pbpg_pkg::REG_BEEP_ON,   16'(beep_on));
        write_reg(pbpg_pkg::REG_OOR_CODE,  {junk[9], 15'(oor)});
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Distance biased toward the pulsed band, with the other classes mixed in.
    function automatic logic [15:0] pick_distance();
        int sel;
        int w;
        int s;
        w   = int'(cfg_warn);
        s   = int'(cfg_stop);
        sel = $urandom_range(99);
        if (sel < 55 && s < w)
            return 16'($urandom_range(w, s + 1));
        if (sel < 68)
            return 16'($urandom_range((s < 1) ? 1 : s, 1));
        if (sel < 73)
            return 16'(cfg_oor);
        if (sel < 83)
            return 16'(w + $urandom_range(100, 1));
        return 16'($urandom());
    endfunction

    // Register profiles for the random part; the second and fourth hit extremes.
    task automatic apply_profile(input int k);
        int w;
        int s;
        int f;
        case (k)
            0: begin
                // short periods so beeps cycle many times per run
                w = $urandom_range(400, 20);
                s = $urandom_range(w - 1, 0);
                f = $urandom_range(8, 1);
                set_config(w, s, f, f + $urandom_range(40, 0), $urandom_range(6, 1),
                           $urandom_range(w, s + 1));
            end
            1: set_config(8191, 0, 1, 65535, 1, 32767);
            2: begin
                // slow below fast and on time longer than the period
                w = $urandom_range(120, 30);
                s = $urandom_range(w - 1, 1);
                set_config(w, s, $urandom_range(14, 6), $urandom_range(5, 1),
                           $urandom_range(30, 15), $urandom_range(32767, 0));
            end
            default: begin
                // warn at or below stop: nothing can be pulsed
                w = $urandom_range(100, 1);
                set_config(w, w + $urandom_range(50, 0), 65535, 1, 65535,
                           $urandom_range(w, 1));
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset defaults: every distance class and the signed extremes.
    task automatic test_distance_classes();
        send_event(pbpg_pkg::FUNC_TICK, 16'h0000);
        send_event(pbpg_pkg::FUNC_DIST, 16'h8000);   // most negative
        send_event(pbpg_pkg::FUNC_DIST, 16'h0000);   // zero
        send_event(pbpg_pkg::FUNC_DIST, 16'hFFFF);   // -1
        send_event(pbpg_pkg::FUNC_DIST, 16'h7FFF);   // far
        send_event(pbpg_pkg::FUNC_DIST, 16'd1);      // continuous
        send_ticks(2);
        send_event(pbpg_pkg::FUNC_DIST, 16'd100);    // exactly at stop
        send_event(pbpg_pkg::FUNC_DIST, 16'd101);    // just into the pulsed band
        send_event(pbpg_pkg::FUNC_DIST, 16'd200);    // exactly at warn
        send_event(pbpg_pkg::FUNC_DIST, 16'd201);    // just beyond warn
    endtask

    // The out-of-range code silences a reading that would otherwise be pulsed.
    task automatic test_out_of_range_code();
        set_config(8191, 100, 150, 600, 50, 5000);
        send_event(pbpg_pkg::FUNC_DIST, 16'd4999);
        send_event(pbpg_pkg::FUNC_DIST, 16'd5000);
        send_event(pbpg_pkg::FUNC_DIST, 16'd5001);
    endtask

    // Warn below stop: only readings up to warn sound, and continuously.
    task automatic test_inverted_thresholds();
        set_config(50, 100, 150, 600, 50, 8190);
        send_event(pbpg_pkg::FUNC_DIST, 16'd40);
        send_event(pbpg_pkg::FUNC_DIST, 16'd75);
        send_event(pbpg_pkg::FUNC_DIST, 16'd150);
    endtask

    // Beep sequencer through on/off edges with one-ms on time.
    task automatic test_pulsed_sequence();
        set_config(40, 10, 2, 8, 1, 8190);
        send_event(pbpg_pkg::FUNC_DIST, 16'd25);
        send_ticks(4);
        send_event(pbpg_pkg::FUNC_DIST, 16'd25);
        send_ticks(4);
        send_event(pbpg_pkg::FUNC_DIST, 16'd40);
        send_ticks(4);
        send_event(pbpg_pkg::FUNC_DIST, 16'd5);      // continuous keeps timing
        send_event(pbpg_pkg::FUNC_DIST, 16'd11);
    endtask

    // Random items: mostly ticks so the ms clock moves, with frequent updates.
    task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int count);
        int per_profile;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        per_profile = count / NUM_PROFILES;
        for (int k = 0; k < NUM_PROFILES; k++) begin
            apply_profile(k);
            repeat (per_profile) begin
                if ($urandom_range(99) < 78)
                    send_event(pbpg_pkg::FUNC_TICK, 16'($urandom()));
                else
                    send_event(pbpg_pkg::FUNC_DIST, pick_distance());
            end
        end
    endtask

    initial begin
        // synchronous reset, asserted once
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_distance_classes();
        test_out_of_range_code();
        test_inverted_thresholds();
        test_pulsed_sequence();
        test_random_traffic(7, 78, RANDOM_ITEMS);
        test_random_traffic(78, 7, RANDOM_ITEMS);
        test_random_traffic(0, 0, RANDOM_ITEMS);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_beeps.size() != 0)
            error_count++;

        $display("Covered %0d input transfers (%0d distance updates), %0d results checked",
                 items_sent, distance_updates, results_checked);
        $display("  %0d pulsed results, %0d register profiles, 3 flow-control mixes",
                 pulsed_results, NUM_PROFILES);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d mismatches", error_count);
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
